>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the allocator modules. Each macro expects
// signals named clk and arst_n in the module that uses it.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/scpa_pkg.sv
// ----------------------------------------------------------------------------
// scpa_pkg
// Shared constants, codes and types of the size-class page allocator.
// ----------------------------------------------------------------------------
package scpa_pkg;

	localparam int NUM_CLASSES     = 8;
	localparam int PAGES_PER_CLASS = 4096;

	// Field widths
	localparam int CLASS_W  = 3;
	localparam int IDX_W    = 12;
	localparam int BYTES_W  = 32;
	localparam int TOTAL_W  = 32;
	localparam int LIVE_W   = 48;
	localparam int LOG2_W   = 5;
	localparam int NCLS_W   = 4;
	localparam int CFG_W    = 5;
	localparam int CFG_IDX_W = 1;

	// Derived storage geometry
	localparam int HEIGHT_W  = $clog2(PAGES_PER_CLASS + 1);
	localparam int SLOT_W    = $clog2(PAGES_PER_CLASS);
	localparam int MEM_DEPTH = NUM_CLASSES * PAGES_PER_CLASS;
	localparam int SHIFT_W   = 6;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SMALLEST_LOG2 = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLASSES       = 1'd1;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_TOO_LARGE = 3'd1,
		ST_EXHAUSTED = 3'd2,
		ST_FULL      = 3'd3,
		ST_BAD_CLASS = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ACCESS,
		S_RESULT
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;  // capture a request word
		logic exec;  // apply the captured request to the class state
	} cmd_t;

endpackage

>>> rtl/scpa_ram.sv
// ----------------------------------------------------------------------------
// scpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module scpa_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/scpa_ctrl.sv
// ----------------------------------------------------------------------------
// scpa_ctrl
// Request sequencer: accepts a word, runs its class access, shows the result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scpa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output logic          done,
	output scpa_pkg::cmd_t cmd
);

	scpa_pkg::state_t state_q;
	scpa_pkg::state_t state_nxt;
	logic             accept;

	assign accept = start && !busy;

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			scpa_pkg::S_IDLE: begin
				if (start) state_nxt = scpa_pkg::S_ACCESS;
			end
			scpa_pkg::S_ACCESS: begin
				state_nxt = scpa_pkg::S_RESULT;
			end
			scpa_pkg::S_RESULT: begin
				state_nxt = start ? scpa_pkg::S_ACCESS : scpa_pkg::S_IDLE;
			end
			default: begin
				state_nxt = scpa_pkg::S_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		busy     = 1'b0;
		done     = 1'b0;
		cmd.exec = 1'b0;
		unique case (state_q)
			scpa_pkg::S_IDLE: begin
			end
			scpa_pkg::S_ACCESS: begin
				busy     = 1'b1;
				cmd.exec = 1'b1;
			end
			scpa_pkg::S_RESULT: begin
				done = 1'b1;
			end
			default: begin
			end
		endcase
		cmd.load = start && (state_q != scpa_pkg::S_ACCESS);
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scpa_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	`ASSERT_NEXT(a_accept_runs, accept, cmd.exec, "accepted word did not start its access")
	`ASSERT_NEXT(a_access_done, cmd.exec, done && !cmd.exec, "access not followed by a result")
	`ASSERT_IMPLIES(a_load_when_free, cmd.load, !busy, "word captured while busy")

endmodule

>>> rtl/scpa_dp.sv
// ----------------------------------------------------------------------------
// scpa_dp
// Allocator datapath: class selection, per-class stack heights and fresh
// indices, the free-index stack memory, running totals and result registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scpa_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  scpa_pkg::cmd_t                       cmd,
	input  logic                                 cfg_we,
	input  logic [scpa_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [scpa_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                 req_type,
	input  logic [scpa_pkg::BYTES_W-1:0]         request_bytes,
	input  logic [scpa_pkg::CLASS_W-1:0]         free_class,
	input  logic [scpa_pkg::IDX_W-1:0]           free_index,
	output logic [2:0]                           status,
	output logic [scpa_pkg::CLASS_W-1:0]         page_class,
	output logic [scpa_pkg::IDX_W-1:0]           page_index,
	output logic [scpa_pkg::TOTAL_W-1:0]         alloc_total,
	output logic [scpa_pkg::TOTAL_W-1:0]         free_total,
	output logic [scpa_pkg::LIVE_W-1:0]          bytes_in_use
);

	localparam int AW = $clog2(scpa_pkg::MEM_DEPTH);

	// Configuration
	logic [scpa_pkg::LOG2_W-1:0] small_log2_q;
	logic [scpa_pkg::NCLS_W-1:0] classes_q;
	logic [scpa_pkg::NCLS_W-1:0] n_enabled;

	// Captured request
	logic                          is_free_q;
	logic                          class_ok_q;
	logic [scpa_pkg::CLASS_W-1:0]  class_q;
	logic [scpa_pkg::IDX_W-1:0]    fidx_q;
	logic [scpa_pkg::SHIFT_W-1:0]  shift_q;

	// Class state
	logic [scpa_pkg::HEIGHT_W-1:0] height_q [scpa_pkg::NUM_CLASSES];
	logic [scpa_pkg::HEIGHT_W-1:0] fresh_q  [scpa_pkg::NUM_CLASSES];
	logic [scpa_pkg::TOTAL_W-1:0]  alloc_q;
	logic [scpa_pkg::TOTAL_W-1:0]  free_q;
	logic [scpa_pkg::LIVE_W-1:0]   live_q;

	// Result registers
	scpa_pkg::status_t             status_q;
	logic [scpa_pkg::CLASS_W-1:0]  ocls_q;
	logic [scpa_pkg::IDX_W-1:0]    oidx_q;
	logic                          pop_q;

	// Selection signals
	logic [scpa_pkg::BYTES_W-1:0]     bytes_m1;
	logic [scpa_pkg::NUM_CLASSES-1:0] hit;
	logic [scpa_pkg::CLASS_W-1:0]     pick;
	logic [scpa_pkg::SHIFT_W-1:0]     lane_shift;
	logic [scpa_pkg::CLASS_W-1:0]     cls_in;
	logic                             ok_in;

	// Access signals
	logic [scpa_pkg::HEIGHT_W-1:0] h_cur;
	logic [scpa_pkg::HEIGHT_W-1:0] f_cur;
	logic [scpa_pkg::HEIGHT_W-1:0] h_dec;
	logic [scpa_pkg::LIVE_W-1:0]   sz;
	logic [scpa_pkg::LIVE_W:0]     live_sum;
	logic [scpa_pkg::LIVE_W-1:0]   live_add;
	logic [scpa_pkg::LIVE_W-1:0]   live_sub;
	logic                          do_pop;
	logic                          do_fresh;
	logic                          do_push;
	scpa_pkg::status_t             st_nxt;
	logic [AW-1:0]                 ram_waddr;
	logic [AW-1:0]                 ram_raddr;
	logic [scpa_pkg::IDX_W-1:0]    ram_rdata;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			small_log2_q <= scpa_pkg::LOG2_W'(13);
			classes_q    <= scpa_pkg::NCLS_W'(scpa_pkg::NUM_CLASSES);
		end else if (cfg_we) begin
			unique case (cfg_index)
				scpa_pkg::CFG_SMALLEST_LOG2: small_log2_q <= cfg_data;
				scpa_pkg::CFG_CLASSES:       classes_q    <= cfg_data[scpa_pkg::NCLS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign n_enabled = (classes_q > scpa_pkg::NCLS_W'(scpa_pkg::NUM_CLASSES)) ?
		scpa_pkg::NCLS_W'(scpa_pkg::NUM_CLASSES) : classes_q;

	// Test each class lane for fit: bytes <= 2^(log2 + c)
	assign bytes_m1 = request_bytes - scpa_pkg::BYTES_W'(1);
	always_comb begin
		for (int c = 0; c < scpa_pkg::NUM_CLASSES; c++) begin
			lane_shift = scpa_pkg::SHIFT_W'(small_log2_q) + scpa_pkg::SHIFT_W'(c);
			hit[c] = ((lane_shift >= scpa_pkg::SHIFT_W'(scpa_pkg::BYTES_W)) ||
				((bytes_m1 >> lane_shift) == '0) || (request_bytes == '0)) &&
				(scpa_pkg::NCLS_W'(c) < n_enabled);
		end
	end

	// Pick the smallest fitting class
	always_comb begin
		pick = '0;
		for (int c = scpa_pkg::NUM_CLASSES - 1; c >= 0; c--) begin
			if (hit[c]) pick = scpa_pkg::CLASS_W'(c);
		end
	end

	assign cls_in = req_type ? free_class : pick;
	assign ok_in  = req_type ?
		((scpa_pkg::NCLS_W'(free_class) < n_enabled) &&
		 ({1'b0, free_index} < scpa_pkg::HEIGHT_W'(scpa_pkg::PAGES_PER_CLASS))) :
		(|hit);

	// Capture the request word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			is_free_q  <= req_type;
			class_ok_q <= ok_in;
			class_q    <= cls_in;
			fidx_q     <= free_index;
			shift_q    <= scpa_pkg::SHIFT_W'(small_log2_q) + scpa_pkg::SHIFT_W'(cls_in);
		end
	end

	// Decide the access for the captured class
	assign h_cur = height_q[class_q];
	assign f_cur = fresh_q[class_q];
	assign h_dec = h_cur - scpa_pkg::HEIGHT_W'(1);
	assign sz    = scpa_pkg::LIVE_W'(1) << shift_q;

	always_comb begin
		do_pop   = 1'b0;
		do_fresh = 1'b0;
		do_push  = 1'b0;
		st_nxt   = scpa_pkg::ST_OK;
		if (!is_free_q) begin
			if (!class_ok_q) begin
				st_nxt = scpa_pkg::ST_TOO_LARGE;
			end else if (h_cur != '0) begin
				do_pop = 1'b1;
			end else if (f_cur < scpa_pkg::HEIGHT_W'(scpa_pkg::PAGES_PER_CLASS)) begin
				do_fresh = 1'b1;
			end else begin
				st_nxt = scpa_pkg::ST_EXHAUSTED;
			end
		end else begin
			if (!class_ok_q) begin
				st_nxt = scpa_pkg::ST_BAD_CLASS;
			end else if (h_cur >= scpa_pkg::HEIGHT_W'(scpa_pkg::PAGES_PER_CLASS)) begin
				st_nxt = scpa_pkg::ST_FULL;
			end else begin
				do_push = 1'b1;
			end
		end
	end

	// Saturating live byte total
	assign live_sum = {1'b0, live_q} + {1'b0, sz};
	assign live_add = live_sum[scpa_pkg::LIVE_W] ? '1 : live_sum[scpa_pkg::LIVE_W-1:0];
	assign live_sub = (live_q < sz) ? '0 : live_q - sz;

	// Update class state and totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < scpa_pkg::NUM_CLASSES; c++) begin
				height_q[c] <= '0;
				fresh_q[c]  <= '0;
			end
			alloc_q <= '0;
			free_q  <= '0;
			live_q  <= '0;
		end else if (cmd.exec) begin
			if (do_pop) height_q[class_q] <= h_dec;
			if (do_push) height_q[class_q] <= h_cur + scpa_pkg::HEIGHT_W'(1);
			if (do_fresh) fresh_q[class_q] <= f_cur + scpa_pkg::HEIGHT_W'(1);
			if (do_pop || do_fresh) begin
				alloc_q <= alloc_q + scpa_pkg::TOTAL_W'(1);
				live_q  <= live_add;
			end
			if (do_push) begin
				free_q <= free_q + scpa_pkg::TOTAL_W'(1);
				live_q <= live_sub;
			end
		end
	end

	// Hold the result word
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q <= st_nxt;
			pop_q    <= do_pop;
			ocls_q   <= (st_nxt == scpa_pkg::ST_OK) ? class_q : '0;
			oidx_q   <= do_push  ? fidx_q :
			            do_fresh ? f_cur[scpa_pkg::IDX_W-1:0] : '0;
		end
	end

	// Free-index stacks, one region per class
	assign ram_waddr = {class_q, h_cur[scpa_pkg::SLOT_W-1:0]};
	assign ram_raddr = {class_q, h_dec[scpa_pkg::SLOT_W-1:0]};

	scpa_ram #(
		.WIDTH (scpa_pkg::IDX_W),
		.DEPTH (scpa_pkg::MEM_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (cmd.exec && do_push),
		.waddr (ram_waddr),
		.wdata (fidx_q),
		.re    (cmd.exec && do_pop),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Drive the result ports
	assign status       = status_q;
	assign page_class   = ocls_q;
	assign page_index   = pop_q ? ram_rdata : oidx_q;
	assign alloc_total  = alloc_q;
	assign free_total   = free_q;
	assign bytes_in_use = live_q;

	`ASSERT_NEXT(a_totals_hold, !cmd.exec, $stable(alloc_q) && $stable(free_q),
		"running totals moved outside an access")
	`ASSERT_IMPLIES(a_height_range, cmd.exec,
		h_cur <= scpa_pkg::HEIGHT_W'(scpa_pkg::PAGES_PER_CLASS), "stack height overflow")
	`ASSERT_ALWAYS(a_one_action, $countones({do_pop, do_fresh, do_push}) <= 1,
		"more than one stack action selected")

endmodule

>>> rtl/size_class_page_id_allocator.sv
// ----------------------------------------------------------------------------
// size_class_page_id_allocator
// Hands out and takes back page indices across power-of-two size classes.
//
// Usage:
//   Request channel: raise start with req_type, request_bytes, free_class and
//   free_index; the word is taken at a clock edge where start is high and
//   busy is low. An allocate picks the smallest enabled class that fits the
//   byte count, pops its most recently freed index or takes a fresh one. A
//   free pushes the index onto its class stack.
//   Result channel: done is high for exactly one cycle per request, with
//   status, page_class, page_index and the running totals valid in that
//   cycle. The receiver cannot stall; the result holds until the next access.
//   Sequence: the accept edge moves the sequencer to its access state, where
//   the stack height read-modify-write and the stack memory access run;
//   done rises with the move to the result state. A new word may be accepted
//   in the result cycle, but not in the access state, while busy is high.
//   Configuration (unguarded): cfg_we, cfg_index, cfg_data write the page size
//   register and class count; users must do so while no request is in flight.
//   Reset: arst_n clears heights, fresh indices, totals and the controller;
//   the stack memory holds no reset value and needs no clearing pass.
// ----------------------------------------------------------------------------
module size_class_page_id_allocator (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [scpa_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [scpa_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 req_type,
	input  logic [scpa_pkg::BYTES_W-1:0]         request_bytes,
	input  logic [scpa_pkg::CLASS_W-1:0]         free_class,
	input  logic [scpa_pkg::IDX_W-1:0]           free_index,
	output logic                                 done,
	output logic [2:0]                           status,
	output logic [scpa_pkg::CLASS_W-1:0]         page_class,
	output logic [scpa_pkg::IDX_W-1:0]           page_index,
	output logic [scpa_pkg::TOTAL_W-1:0]         alloc_total,
	output logic [scpa_pkg::TOTAL_W-1:0]         free_total,
	output logic [scpa_pkg::LIVE_W-1:0]          bytes_in_use
);

	scpa_pkg::cmd_t cmd;

	// Sequencer
	scpa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// Class state and stacks
	scpa_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.req_type      (req_type),
		.request_bytes (request_bytes),
		.free_class    (free_class),
		.free_index    (free_index),
		.status        (status),
		.page_class    (page_class),
		.page_index    (page_index),
		.alloc_total   (alloc_total),
		.free_total    (free_total),
		.bytes_in_use  (bytes_in_use)
	);

endmodule
